@@ rtl/oriented_rect_cell_raster_defines.svh @@
// assertion macros for the oriented rectangle cell raster
// used by the top level only; expects clk and arst_n in scope
`ifndef ORIENTED_RECT_CELL_RASTER_DEFINES_SVH
`define ORIENTED_RECT_CELL_RASTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ORCR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define ORCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/orcr_pkg.sv @@
// shared types and constants for the oriented rectangle cell raster
// no dependencies
`default_nettype none
package orcr_pkg;

	localparam int MASK_COLUMNS = 32;
	localparam int MAX_ROWS     = 64;

	localparam int DIV_W  = 26;  // magnitude of the shifted numerator
	localparam int IDX_W  = DIV_W + 1;  // signed cell index
	localparam int CELL_W = 16;

	localparam logic [1:0] REG_RASTER_HALF = 2'd0;
	localparam logic [1:0] REG_CELL_SIZE   = 2'd1;

	typedef struct packed {
		logic signed [23:0] center_x;
		logic signed [23:0] center_z;
		logic        [22:0] rect_width;
		logic        [22:0] rect_depth;
		logic signed [15:0] cos_angle;
		logic signed [15:0] sin_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] row_index;
		logic signed [15:0] first_column;
		logic        [31:0] column_mask;
		logic               clipped;
		logic               last_row;
	} out_item_t;

endpackage
`default_nettype wire

@@ rtl/orcr_div.sv @@
// iterative floor divider: signed numerator by unsigned cell size, one bit per cycle
// depends on orcr_pkg
`default_nettype none
module orcr_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [orcr_pkg::DIV_W-1:0]  num,
	input  wire logic        [orcr_pkg::CELL_W-1:0] den,
	output logic                                    done,
	output logic signed [orcr_pkg::IDX_W-1:0]       quot
);
	localparam int CNT_W = $clog2(orcr_pkg::DIV_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [orcr_pkg::DIV_W-1:0]    mag_q;
	logic [orcr_pkg::CELL_W-1:0]   rem_q;
	logic                          neg_q;
	logic [orcr_pkg::CELL_W:0]     trial;
	logic                          fits;
	logic [orcr_pkg::IDX_W-1:0]    qext;

	assign trial = {rem_q, mag_q[orcr_pkg::DIV_W-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(orcr_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[orcr_pkg::DIV_W-1];
			mag_q <= num[orcr_pkg::DIV_W-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? orcr_pkg::CELL_W'(trial - {1'b0, den}) : trial[orcr_pkg::CELL_W-1:0];
			mag_q <= {mag_q[orcr_pkg::DIV_W-2:0], fits};
		end
	end

	// floor for negative numerators: minus the ceiling of the magnitude quotient
	assign qext = {1'b0, mag_q} + orcr_pkg::IDX_W'(rem_q != '0);
	assign quot = neg_q ? -$signed(qext) : $signed({1'b0, mag_q});
	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/oriented_rect_cell_raster.sv @@
// setup after acceptance: 7 products, four divisions on the bit-serial divider, 8 more steps;
// then per row a column scan of ncols cells and an emit step that waits while out_stall is high,
// ncols up to 32, rows up to 64; one rectangle at a time, as the shared multiplier, the
// bit-serial divider and the column scan serve one rectangle; in_stall is high from acceptance
// until the last row is loaded out
// reset: async active low, sequencer idle, raster_half 0, cell_size 256, output empty
`default_nettype none
`include "oriented_rect_cell_raster_defines.svh"
module oriented_rect_cell_raster (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [22:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire orcr_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output orcr_pkg::out_item_t      out_data
);
	localparam int IW = orcr_pkg::IDX_W;
	localparam int PW = 46;
	localparam int EW = 39;
	localparam int CW = $clog2(orcr_pkg::MASK_COLUMNS);
	localparam int RW = $clog2(orcr_pkg::MAX_ROWS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MUL    = 4'd1;
	localparam logic [3:0] ST_DSTART = 4'd2;
	localparam logic [3:0] ST_DWAIT  = 4'd3;
	localparam logic [3:0] ST_MUL2   = 4'd4;
	localparam logic [3:0] ST_ORG    = 4'd5;
	localparam logic [3:0] ST_MUL3   = 4'd6;
	localparam logic [3:0] ST_INIT   = 4'd7;
	localparam logic [3:0] ST_COL    = 4'd8;
	localparam logic [3:0] ST_EMIT   = 4'd9;

	logic [3:0]  state_q;
	logic [2:0]  step_q;
	logic [1:0]  dsel_q;

	logic [22:0] raster_half_q;
	logic [15:0] cell_size_q;
	logic [15:0] cell_eff;

	logic signed [23:0] cx_q, cz_q;
	logic        [22:0] w_q, d_q;
	logic signed [15:0] c_q, s_q;

	logic [37:0] wc_q, ds_q, ws_q, dc_q;
	logic [32:0] r_q;
	logic signed [32:0] cc_q, cs_q;
	logic signed [IW-1:0] lo_x_q, hi_x_q, lo_z_q, hi_z_q;
	logic signed [42:0] lxc_q, lzc_q;
	logic signed [27:0] dx0_q, dz0_q;
	logic signed [PW-1:0] pu_r_q, pv_r_q, tu_q, tv_q, pu_c_q, pv_c_q;
	logic signed [EW-1:0] ext_u_q, ext_v_q;
	logic [CW-1:0] ncols_m1_q, col_q;
	logic [RW-1:0] nrows_m1_q, row_cnt_q;
	logic signed [IW-1:0] row_q;
	logic clip_q;
	logic [orcr_pkg::MASK_COLUMNS-1:0] mask_q;

	logic out_valid_q;
	orcr_pkg::out_item_t out_q;

	// shared multiplier
	logic signed [27:0]   mul_a;
	logic signed [17:0]   mul_b;
	logic signed [PW-1:0] prod;
	logic [PW-1:0]        prod_abs;
	logic [16:0]          abs_c, abs_s;

	// divider hookup
	logic                          div_done;
	logic signed [IW-1:0]          div_q;
	logic signed [orcr_pkg::DIV_W-1:0] div_num;
	logic signed [24:0] base_x, base_z;
	logic [38:0] spx, spz;
	logic signed [40:0] numer;

	logic signed [IW-1:0] dxs, dzs;
	logic signed [44:0] dx0_full, dz0_full;
	logic signed [PW-1:0] step_cu, step_cv, step_ru, step_rv;
	logic [PW-1:0] apu, apv;
	logic hit;
	logic out_take, out_free;

	assign cell_eff = (cell_size_q == '0) ? 16'd1 : cell_size_q;
	assign abs_c = c_q[15] ? 17'(-$signed({c_q[15], c_q})) : {1'b0, c_q};
	assign abs_s = s_q[15] ? 17'(-$signed({s_q[15], s_q})) : {1'b0, s_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL: begin
				case (step_q)
					3'd0: begin mul_a = 28'($signed({1'b0, w_q})); mul_b = 18'(c_q); end
					3'd1: begin mul_a = 28'($signed({1'b0, d_q})); mul_b = 18'(s_q); end
					3'd2: begin mul_a = 28'($signed({1'b0, w_q})); mul_b = 18'(s_q); end
					3'd3: begin mul_a = 28'($signed({1'b0, d_q})); mul_b = 18'(c_q); end
					3'd4: begin
						mul_a = 28'($signed({1'b0, cell_eff}));
						mul_b = $signed({1'b0, 17'(abs_c + abs_s)});
					end
					3'd5: begin mul_a = 28'($signed({1'b0, cell_eff})); mul_b = 18'(c_q); end
					default: begin mul_a = 28'($signed({1'b0, cell_eff})); mul_b = 18'(s_q); end
				endcase
			end
			ST_MUL2: begin
				mul_a = 28'(step_q[0] ? lo_z_q : lo_x_q);
				mul_b = 18'($signed({1'b0, cell_eff}));
			end
			ST_MUL3: begin
				case (step_q[1:0])
					2'd0: begin mul_a = dx0_q; mul_b = 18'(c_q); end
					2'd1: begin mul_a = dz0_q; mul_b = 18'(s_q); end
					2'd2: begin mul_a = dz0_q; mul_b = 18'(c_q); end
					default: begin mul_a = dx0_q; mul_b = 18'(s_q); end
				endcase
			end
			default: ;
		endcase
	end

	assign prod     = PW'(mul_a) * PW'(mul_b);
	assign prod_abs = prod[PW-1] ? PW'(-prod) : prod;

	// numerators: (center + half) * 2^15 -/+ spread, floored by 2^15 before the division
	assign base_x = 25'(cx_q) + 25'($signed({2'b0, raster_half_q}));
	assign base_z = 25'(cz_q) + 25'($signed({2'b0, raster_half_q}));
	assign spx    = 39'(wc_q) + 39'(ds_q);
	assign spz    = 39'(ws_q) + 39'(dc_q);

	always_comb begin
		case (dsel_q)
			2'd0:    numer = {base_x[24], base_x, 15'd0} - {2'b0, spx};
			2'd1:    numer = {base_x[24], base_x, 15'd0} + {2'b0, spx};
			2'd2:    numer = {base_z[24], base_z, 15'd0} - {2'b0, spz};
			default: numer = {base_z[24], base_z, 15'd0} + {2'b0, spz};
		endcase
	end
	assign div_num = numer[40:15];

	orcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DSTART),
		.num    (div_num),
		.den    (cell_eff),
		.done   (div_done),
		.quot   (div_q)
	);

	assign dxs = hi_x_q - lo_x_q;
	assign dzs = hi_z_q - lo_z_q;

	// cell centre offsets of the first column and row, in half units
	assign dx0_full = 45'(lxc_q) * 2 + 45'($signed({1'b0, cell_eff}))
		- 45'($signed({1'b0, raster_half_q})) * 2 - 45'(cx_q) * 2;
	assign dz0_full = 45'(lzc_q) * 2 + 45'($signed({1'b0, cell_eff}))
		- 45'($signed({1'b0, raster_half_q})) * 2 - 45'(cz_q) * 2;

	assign step_cu = PW'(cc_q) * 2;
	assign step_cv = PW'(cs_q) * 2;
	assign step_ru = PW'(cs_q) * 2;
	assign step_rv = PW'(cc_q) * 2;

	assign apu = pu_c_q[PW-1] ? PW'(-pu_c_q) : pu_c_q;
	assign apv = pv_c_q[PW-1] ? PW'(-pv_c_q) : pv_c_q;
	assign hit = !ext_u_q[EW-1] && !ext_v_q[EW-1]
		&& (apu <= PW'(ext_u_q[EW-2:0])) && (apv <= PW'(ext_v_q[EW-2:0]));

	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_half_q <= '0;
			cell_size_q   <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				orcr_pkg::REG_RASTER_HALF: raster_half_q <= cfg_data;
				orcr_pkg::REG_CELL_SIZE:   cell_size_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			dsel_q      <= '0;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_cnt_q   <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_take)                  out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd6) begin
						state_q <= ST_DSTART;
						dsel_q  <= '0;
					end
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						dsel_q <= dsel_q + 1'b1;
						if (dsel_q == 2'd3) begin
							state_q <= ST_MUL2;
							step_q  <= '0;
						end else begin
							state_q <= ST_DSTART;
						end
					end
				end
				ST_MUL2: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1) state_q <= ST_ORG;
				end
				ST_ORG: begin
					state_q <= ST_MUL3;
					step_q  <= '0;
				end
				ST_MUL3: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd3) state_q <= ST_INIT;
				end
				ST_INIT: begin
					state_q   <= ST_COL;
					col_q     <= '0;
					row_cnt_q <= '0;
				end
				ST_COL: begin
					col_q <= col_q + 1'b1;
					if (col_q == ncols_m1_q) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						col_q <= '0;
						if (row_cnt_q == nrows_m1_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q   <= ST_COL;
							row_cnt_q <= row_cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cx_q <= in_data.center_x;
			cz_q <= in_data.center_z;
			w_q  <= in_data.rect_width;
			d_q  <= in_data.rect_depth;
			c_q  <= in_data.cos_angle;
			s_q  <= in_data.sin_angle;
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				3'd0: wc_q <= prod_abs[37:0];
				3'd1: ds_q <= prod_abs[37:0];
				3'd2: ws_q <= prod_abs[37:0];
				3'd3: dc_q <= prod_abs[37:0];
				3'd4: r_q  <= prod[32:0];
				3'd5: cc_q <= prod[32:0];
				default: cs_q <= prod[32:0];
			endcase
		end
		if (state_q == ST_DWAIT && div_done) begin
			case (dsel_q)
				2'd0:    lo_x_q <= div_q;
				2'd1:    hi_x_q <= div_q;
				2'd2:    lo_z_q <= div_q;
				default: hi_z_q <= div_q;
			endcase
		end
		if (state_q == ST_MUL2) begin
			if (step_q[0]) lzc_q <= prod[42:0];
			else           lxc_q <= prod[42:0];
		end
		if (state_q == ST_ORG) begin
			dx0_q <= dx0_full[27:0];
			dz0_q <= dz0_full[27:0];
		end
		if (state_q == ST_MUL3) begin
			case (step_q[1:0])
				2'd0:    pu_r_q <= prod;
				2'd1:    tu_q   <= prod;
				2'd2:    pv_r_q <= prod;
				default: tv_q   <= prod;
			endcase
		end
		if (state_q == ST_INIT) begin
			pu_r_q <= pu_r_q + tu_q;
			pv_r_q <= pv_r_q - tv_q;
			pu_c_q <= pu_r_q + tu_q;
			pv_c_q <= pv_r_q - tv_q;
			ext_u_q <= $signed({2'b0, w_q, 14'd0}) + EW'($signed({1'b0, r_q})) - 1;
			ext_v_q <= $signed({2'b0, d_q, 14'd0}) + EW'($signed({1'b0, r_q})) - 1;
			ncols_m1_q <= (dxs > IW'(orcr_pkg::MASK_COLUMNS - 1)) ? CW'(orcr_pkg::MASK_COLUMNS - 1)
				: dxs[CW-1:0];
			nrows_m1_q <= (dzs > IW'(orcr_pkg::MAX_ROWS - 1)) ? RW'(orcr_pkg::MAX_ROWS - 1)
				: dzs[RW-1:0];
			clip_q <= (dxs > IW'(orcr_pkg::MASK_COLUMNS - 1)) || (dzs > IW'(orcr_pkg::MAX_ROWS - 1));
			row_q  <= lo_z_q;
			mask_q <= '0;
		end
		if (state_q == ST_COL) begin
			mask_q[col_q] <= hit;
			pu_c_q <= pu_c_q + step_cu;
			pv_c_q <= pv_c_q - step_cv;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.row_index    <= row_q[15:0];
			out_q.first_column <= lo_x_q[15:0];
			out_q.column_mask  <= 32'(mask_q);
			out_q.clipped      <= clip_q;
			out_q.last_row     <= (row_cnt_q == nrows_m1_q);
			row_q  <= row_q + 1'b1;
			mask_q <= '0;
			pu_r_q <= pu_r_q + step_ru;
			pv_r_q <= pv_r_q + step_rv;
			pu_c_q <= pu_r_q + step_ru;
			pv_c_q <= pv_r_q + step_rv;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a taken rectangle keeps the input side closed on the next cycle
	`ORCR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")
	// the divider only finishes while the sequencer waits for it
	`ORCR_ASSERT_NOW(a_div_done_wait, div_done, state_q == ST_DWAIT, "divider done out of turn")
	// column scan never passes the clipped column count
	`ORCR_ASSERT_NOW(a_col_bound, state_q == ST_COL, col_q <= ncols_m1_q, "column past limit")
	// loading the last row leaves it valid on the output with last_row set
	`ORCR_ASSERT_NEXT(a_last_loaded, state_q == ST_EMIT && out_free && row_cnt_q == nrows_m1_q,
		out_valid && out_data.last_row, "last row not flagged")

endmodule
`default_nettype wire
